// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ESD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ESD_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ESD_ASSERT_IMP(label, clk, rst_n, a, c)
`define ESD_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/esd_pkg.sv -----
package esd_pkg;

    localparam int unsigned EdgesDefault = 8192;
    localparam logic [31:0] DefStiffReset = 32'd65536000;
    localparam logic [31:0] StrengthReset = 32'd3276800;
    localparam logic [15:0] DmgScaleReset = 16'd1049;
    localparam logic [23:0] LenEps = 24'd7;
    localparam logic [31:0] OneQ16 = 32'd65536;

    localparam int unsigned SqrtSteps = 25;
    localparam int unsigned DivSteps = 56;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EVAL  = 2'd1,
        OP_BREAK = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_DEF_STIFF = 2'd0,
        CFG_STRENGTH  = 2'd1,
        CFG_DMG_SCALE = 2'd2,
        CFG_NONE      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [12:0]        edge_req;
        logic signed [23:0] dx;
        logic signed [23:0] dy;
        logic signed [23:0] dz;
        logic [31:0]        stiff_in;
    } in_beat_t;

    typedef struct packed {
        logic [23:0]        length;
        logic signed [31:0] strain;
        logic [31:0]        stress;
        logic [31:0]        damage;
        logic               intact;
        logic               just_broke;
    } out_beat_t;

endpackage

// ----- rtl/esd_sqrt.sv -----
// Pipelined integer square root of a 50 bit value, one result bit per stage.
module esd_sqrt
    import esd_pkg::*;
#(
    parameter int unsigned TagW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [49:0]     radicand,
    input  logic [TagW-1:0] tag_in,
    output logic [24:0]     root,
    output logic [TagW-1:0] tag_out
);

    logic [49:0]     rem_reg  [SqrtSteps];
    logic [24:0]     root_reg [SqrtSteps];
    logic [TagW-1:0] tag_reg  [SqrtSteps];

    logic [49:0]     rem_cur   [SqrtSteps];
    logic [24:0]     root_cur  [SqrtSteps];
    logic [TagW-1:0] tag_cur   [SqrtSteps];
    logic [49:0]     rem_next  [SqrtSteps];
    logic [24:0]     root_next [SqrtSteps];

    always_comb
    begin
        rem_cur[0]  = radicand;
        root_cur[0] = '0;
        tag_cur[0]  = tag_in;
        for (int s = 1; s < SqrtSteps; s++)
        begin
            rem_cur[s]  = rem_reg[s-1];
            root_cur[s] = root_reg[s-1];
            tag_cur[s]  = tag_reg[s-1];
        end
    end

    always_comb
    begin
        logic [51:0] trial;
        logic [51:0] remw;
        for (int s = 0; s < SqrtSteps; s++)
        begin
            trial = ({25'd0, root_cur[s], 2'b01}) << (2 * (SqrtSteps - 1 - s));
            remw  = {2'b00, rem_cur[s]};
            if (remw >= trial)
            begin
                rem_next[s]  = 50'(remw - trial);
                root_next[s] = {root_cur[s][23:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem_cur[s];
                root_next[s] = {root_cur[s][23:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SqrtSteps; s++)
                tag_reg[s] <= '0;
        end
        else if (en)
        begin
            for (int s = 0; s < SqrtSteps; s++)
                tag_reg[s] <= tag_cur[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < SqrtSteps; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign root    = root_reg[SqrtSteps-1];
    assign tag_out = tag_reg[SqrtSteps-1];

    logic unused_rem;
    assign unused_rem = |rem_reg[SqrtSteps-1];

endmodule

// ----- rtl/esd_div.sv -----
// Pipelined restoring divider, 56 bit numerator by 32 bit divisor.
module esd_div
    import esd_pkg::*;
#(
    parameter int unsigned TagW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [55:0]     num,
    input  logic [31:0]     den,
    input  logic [TagW-1:0] tag_in,
    output logic [55:0]     quo,
    output logic [TagW-1:0] tag_out
);

    logic [55:0]     q_reg   [DivSteps];
    logic [32:0]     r_reg   [DivSteps];
    logic [31:0]     d_reg   [DivSteps];
    logic [TagW-1:0] tag_reg [DivSteps];

    logic [55:0]     q_cur   [DivSteps];
    logic [32:0]     r_cur   [DivSteps];
    logic [31:0]     d_cur   [DivSteps];
    logic [TagW-1:0] tag_cur [DivSteps];
    logic [55:0]     q_next  [DivSteps];
    logic [32:0]     r_next  [DivSteps];

    always_comb
    begin
        q_cur[0]   = num;
        r_cur[0]   = '0;
        d_cur[0]   = den;
        tag_cur[0] = tag_in;
        for (int s = 1; s < DivSteps; s++)
        begin
            q_cur[s]   = q_reg[s-1];
            r_cur[s]   = r_reg[s-1];
            d_cur[s]   = d_reg[s-1];
            tag_cur[s] = tag_reg[s-1];
        end
    end

    always_comb
    begin
        logic [32:0] sh;
        for (int s = 0; s < DivSteps; s++)
        begin
            sh = {r_cur[s][31:0], q_cur[s][55]};
            if (sh >= {1'b0, d_cur[s]})
            begin
                r_next[s] = sh - {1'b0, d_cur[s]};
                q_next[s] = {q_cur[s][54:0], 1'b1};
            end
            else
            begin
                r_next[s] = sh;
                q_next[s] = {q_cur[s][54:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DivSteps; s++)
                tag_reg[s] <= '0;
        end
        else if (en)
        begin
            for (int s = 0; s < DivSteps; s++)
                tag_reg[s] <= tag_cur[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DivSteps; s++)
            begin
                q_reg[s] <= q_next[s];
                r_reg[s] <= r_next[s];
                d_reg[s] <= d_cur[s];
            end
        end
    end

    assign quo     = q_reg[DivSteps-1];
    assign tag_out = tag_reg[DivSteps-1];

    logic unused_r;
    assign unused_r = |r_reg[DivSteps-1];

endmodule

// ----- rtl/edge_strain_damage_unit.sv -----
// Edge strain and damage unit: one item per cycle while in_stall is low, one result beat per item.
// From input beat to result beat each item passes through
// a 25 stage square root, two 56 stage dividers, multiplier stages and a read-modify-write
// of damage and intact flag at the tail, forwarded from the write one beat ahead.
// The whole pipeline advances only when the result register is free.
// After rst_n a clearing pass over all EDGES entries zeroes intact flags and damage with in_stall high.
`include "assert_macros.svh"
module edge_strain_damage_unit
    import esd_pkg::*;
#(
    parameter int unsigned EDGES = EdgesDefault
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data,
    input  logic      cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned AW = (EDGES > 1) ? $clog2(EDGES) : 1;

    typedef struct packed {
        logic        vld;
        logic [1:0]  op;
        logic        inr;
        logic [AW-1:0] idx;
        logic [31:0] stiff;
        logic [23:0] len;
    } ctl_t;
    localparam int unsigned CW = $bits(ctl_t);

    logic [31:0] def_stiff_reg, strength_reg;
    logic [15:0] dmg_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_stiff_reg <= DefStiffReset;
            strength_reg  <= StrengthReset;
            dmg_scale_reg <= DmgScaleReset;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEF_STIFF: def_stiff_reg <= cfg_data;
                CFG_STRENGTH:  strength_reg  <= cfg_data;
                CFG_DMG_SCALE: dmg_scale_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic clr_busy_reg;
    logic [AW-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == AW'(EDGES - 1))
                clr_busy_reg <= 1'b0;
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    logic adv;
    logic take;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv || clr_busy_reg;
    assign take     = in_valid && !clr_busy_reg;

    // Front: magnitudes and squares.
    function automatic logic [23:0] mag24(input logic [23:0] v);
        return v[23] ? 24'(-v) : v;
    endfunction

    ctl_t c0_reg;
    logic [23:0] ax_reg, ay_reg, az_reg;
    logic [47:0] sx_reg, sy_reg, sz_reg;
    ctl_t c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
            c1_reg <= '0;
        end
        else if (adv)
        begin
            c0_reg.vld   <= take;
            c0_reg.op    <= in_data.op;
            c0_reg.inr   <= 32'(in_data.edge_req) < EDGES;
            c0_reg.idx   <= AW'(in_data.edge_req);
            c0_reg.stiff <= in_data.stiff_in;
            c0_reg.len   <= '0;
            c1_reg       <= c0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg <= mag24(in_data.dx);
            ay_reg <= mag24(in_data.dy);
            az_reg <= mag24(in_data.dz);
            sx_reg <= ax_reg * ax_reg;
            sy_reg <= ay_reg * ay_reg;
            sz_reg <= az_reg * az_reg;
        end
    end

    logic [49:0] sumsq;
    assign sumsq = 50'(sx_reg) + 50'(sy_reg) + 50'(sz_reg);

    logic [24:0] root;
    logic [CW-1:0] sq_tag;
    ctl_t c2;

    esd_sqrt #(.TagW(CW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(adv), .radicand(sumsq),
        .tag_in(c1_reg), .root(root), .tag_out(sq_tag)
    );

    always_comb
    begin
        c2 = ctl_t'(sq_tag);
        c2.len = root[24] ? 24'hFFFFFF : root[23:0];
    end

    // Rest length and stiffness: written by load and read at the same stage.
    logic [55:0] geom_mem [EDGES];
    logic [55:0] rd_geom_reg;
    ctl_t ca_reg;

    logic wl_en;
    logic [31:0] ld_stiff;
    assign ld_stiff = (c2.stiff != 32'd0) ? c2.stiff : def_stiff_reg;
    assign wl_en = adv && c2.vld && c2.inr && c2.op == OP_LOAD;

    always_ff @(posedge clk)
    begin
        if (adv)
            rd_geom_reg <= geom_mem[c2.idx];
        if (wl_en)
            geom_mem[c2.idx] <= {c2.len, ld_stiff};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ca_reg <= '0;
        else if (adv)
            ca_reg <= c2;
    end

    // Strain division: num = (len - rest) << 16 signed; divide magnitudes.
    logic signed [25:0] diff;
    logic [55:0] dnum;
    ctl_t cb;
    logic [31:0] b_stiff;
    logic [23:0] b_rest;

    always_comb
    begin
        cb      = ca_reg;
        b_rest  = rd_geom_reg[55:32];
        b_stiff = rd_geom_reg[31:0];
        diff    = 26'($signed({2'b00, cb.len})) - 26'($signed({2'b00, b_rest}));
        dnum    = {14'd0, (diff[25] ? 26'(-diff) : diff), 16'd0};
    end

    typedef struct packed {
        ctl_t        c;
        logic [23:0] rest;
        logic [31:0] stiff;
        logic        neg;
    } st1_t;
    localparam int unsigned S1W = $bits(st1_t);

    st1_t s1_in, s1_out;
    logic [55:0] q1;
    logic [S1W-1:0] t1;
    assign s1_in = '{c: cb, rest: b_rest, stiff: b_stiff, neg: diff[25]};

    esd_div #(.TagW(S1W)) u_div_strain (
        .clk(clk), .rst_n(rst_n), .en(adv), .num(dnum),
        .den((b_rest == 24'd0) ? 32'd1 : {8'd0, b_rest}),
        .tag_in(s1_in), .quo(q1), .tag_out(t1)
    );
    assign s1_out = st1_t'(t1);

    // Saturate strain and multiply by stiffness.
    logic signed [31:0] strain_c;
    logic [31:0] smag_c;
    logic        ev_ok;
    always_comb
    begin
        ev_ok = s1_out.c.vld && s1_out.c.inr && s1_out.c.op == OP_EVAL
                && s1_out.c.len >= LenEps;
        if (s1_out.rest == 24'd0)
            strain_c = 32'sh7FFFFFFF;
        else if (s1_out.neg)
            strain_c = (q1 > 56'h80000000) ? 32'sh80000000 : 32'(-q1);
        else
            strain_c = (q1 > 56'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(q1);
        smag_c = strain_c[31] ? 32'(-strain_c) : strain_c;
        if (!ev_ok)
        begin
            strain_c = '0;
            smag_c   = '0;
        end
    end

    st1_t m1_reg;
    logic signed [31:0] m1_strain_reg;
    logic [31:0] m1_smag_reg;
    logic m1_ok_reg;
    logic [63:0] m2_prod_reg;
    st1_t m2_reg;
    logic signed [31:0] m2_strain_reg;
    logic m2_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg <= '0;
            m2_reg <= '0;
        end
        else if (adv)
        begin
            m1_reg <= s1_out;
            m2_reg <= m1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_strain_reg <= strain_c;
            m1_smag_reg <= smag_c;
            m1_ok_reg <= ev_ok;
            m2_prod_reg <= m1_smag_reg * m1_reg.stiff;
            m2_strain_reg <= m1_strain_reg;
            m2_ok_reg <= m1_ok_reg;
        end
    end

    logic [31:0] stress_c;
    assign stress_c = (m2_prod_reg[63:48] != 16'd0) ? 32'hFFFFFFFF : m2_prod_reg[47:16];

    logic over;
    assign over = m2_ok_reg && stress_c > strength_reg;

    typedef struct packed {
        st1_t        s;
        logic signed [31:0] strain;
        logic [31:0] stress;
        logic        over;
        logic [15:0] scale;
    } st2_t;
    localparam int unsigned S2W = $bits(st2_t);

    st2_t s2_in, s2_out;
    logic [55:0] q2;
    logic [S2W-1:0] t2;
    assign s2_in = '{s: m2_reg, strain: m2_strain_reg, stress: stress_c,
                     over: over, scale: dmg_scale_reg};

    esd_div #(.TagW(S2W)) u_div_rate (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .num({8'd0, (over ? stress_c - strength_reg : 32'd0), 16'd0}),
        .den((strength_reg == 32'd0) ? 32'd1 : strength_reg),
        .tag_in(s2_in), .quo(q2), .tag_out(t2)
    );
    assign s2_out = st2_t'(t2);

    st2_t r1_reg;
    logic [55:0] r1_rate_reg;
    st2_t r2_reg;
    logic [71:0] r2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_reg <= '0;
            r2_reg <= '0;
        end
        else if (adv)
        begin
            r1_reg <= s2_out;
            r2_reg <= r1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_rate_reg <= q2;
            r2_prod_reg <= r1_rate_reg * r1_reg.scale;
        end
    end

    // Intact flag and damage: read as a beat enters the last stage and written
    // as it leaves, so only the beat one ahead can overlap and is forwarded.
    logic [32:0] dmg_mem [EDGES];
    logic [32:0] rd_dmg_reg;
    logic        fwd_reg;
    logic [32:0] fwd_val_reg;
    logic        tail_we;
    logic [32:0] tail_wdata;
    logic        dmg_we;
    logic [AW-1:0] dmg_widx;
    logic [32:0] dmg_wdata;
    ctl_t cf;

    assign dmg_we    = clr_busy_reg || tail_we;
    assign dmg_widx  = clr_busy_reg ? clr_idx_reg : cf.idx;
    assign dmg_wdata = clr_busy_reg ? 33'd0 : tail_wdata;

    always_ff @(posedge clk)
    begin
        if (adv)
            rd_dmg_reg <= dmg_mem[r1_reg.s.c.idx];
        if (dmg_we)
            dmg_mem[dmg_widx] <= dmg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg     <= 1'b0;
            fwd_val_reg <= '0;
        end
        else if (adv)
        begin
            fwd_reg     <= tail_we && cf.idx == r1_reg.s.c.idx;
            fwd_val_reg <= tail_wdata;
        end
    end

    logic        cur_itc;
    logic [31:0] cur_dmg;
    logic [56:0] nd;
    logic [31:0] ndmg;
    out_beat_t res;
    always_comb
    begin
        cf      = r2_reg.s.c;
        cur_itc = fwd_reg ? fwd_val_reg[32] : rd_dmg_reg[32];
        cur_dmg = fwd_reg ? fwd_val_reg[31:0] : rd_dmg_reg[31:0];
        nd   = 57'(cur_dmg) + 57'(r2_prod_reg[71:16]);
        ndmg = (nd[56:32] != '0) ? 32'hFFFFFFFF : nd[31:0];
        res  = '0;
        tail_we = 1'b0;
        tail_wdata = {cur_itc, cur_dmg};
        if (cf.vld && cf.inr)
        begin
            case (op_t'(cf.op))
                OP_LOAD:
                begin
                    res.length = cf.len;
                    res.intact = 1'b1;
                    tail_we = adv;
                    tail_wdata = {1'b1, 32'd0};
                end
                OP_EVAL:
                begin
                    res.damage = cur_dmg;
                    if (cur_itc)
                    begin
                        res.intact = 1'b1;
                        res.length = cf.len;
                        res.strain = r2_reg.strain;
                        res.stress = r2_reg.stress;
                        if (r2_reg.over)
                        begin
                            res.damage = ndmg;
                            tail_we = adv;
                            tail_wdata = {1'b1, ndmg};
                            if (ndmg >= OneQ16)
                            begin
                                res.intact = 1'b0;
                                res.just_broke = 1'b1;
                                tail_wdata = {1'b0, ndmg};
                            end
                        end
                    end
                end
                OP_BREAK:
                begin
                    res.length = r2_reg.s.rest;
                    res.damage = cur_dmg;
                    res.just_broke = cur_itc;
                    tail_we = adv;
                    tail_wdata = {1'b0, cur_dmg};
                end
                default: ;
            endcase
        end
    end

    out_beat_t out_reg;
    logic out_vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= cf.vld;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    `ESD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `ESD_ASSERT_IMP(a_break_excl, clk, rst_n, out_valid && out_data.just_broke, !out_data.intact)
    `ESD_ASSERT_IMP(a_load_clean, clk, rst_n, wl_en, c2.inr)
    `ESD_ASSERT_IMP(a_clear_stall, clk, rst_n, clr_busy_reg, in_stall)

endmodule
